/* design/ievq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ievq_pkg
// shared types and codes of the input event queue: item and result beats,
// stored entry layout, opcodes and entry kinds
// ----------------------------------------------------------------------------
package ievq_pkg;

    // opcodes of an input beat
    localparam logic [2:0] OP_KEY       = 3'd0;
    localparam logic [2:0] OP_BUTTON    = 3'd1;
    localparam logic [2:0] OP_POS       = 3'd2;
    localparam logic [2:0] OP_POP       = 3'd3;
    localparam logic [2:0] OP_CLR_LOST  = 3'd4;

    // kinds of a stored event
    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_BUTTON  = 2'd1;
    localparam logic [1:0] KIND_POS     = 2'd2;

    // largest value the count field can show
    localparam int unsigned COUNT_MAX   = 31;

    // key down map held as rows of eight keys, row from the upper key bits
    localparam int unsigned KEY_ROWS    = 16;
    localparam int unsigned KEY_ROW_W   = 8;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  key_code;
        logic        pressed;
        logic [15:0] pos_h;
        logic [15:0] pos_v;
    } t_item;

    typedef struct packed {
        logic        event_valid;
        logic [1:0]  event_kind;
        logic [6:0]  event_key;
        logic        event_pressed;
        logic [15:0] event_h;
        logic [15:0] event_v;
        logic        events_lost;
        logic        activity;
        logic [4:0]  queue_count;
    } t_result;

    // one queue entry, 42 bits
    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  key;
        logic        pressed;
        logic [15:0] h;
        logic [15:0] v;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

/* design/ievq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ievq_ram
// generic simple dual port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module ievq_ram #(
    parameter int unsigned WIDTH = 42,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/input_event_queue_coalescing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_queue_coalescing
// input event ring queue with change detection: key map, button and last
// position are tracked, changes are queued, position beats fold into a
// newest position entry, drops on a full queue set a sticky lost flag
// ----------------------------------------------------------------------------
//
//  channel   signals                 direction  handshake
//  -------   ---------------------   ---------  ------------------------------
//  item      start, i_item, busy     in         taken when start and not busy
//  result    o_strobe, o_result      out        one cycle per beat, no stall
//
//  for every item the accept edge launches the ram reads
//  (head slot for a pop, newest slot otherwise, and the key map row of
//  the key code), the next cycle holds busy, does the read-modify-write
//  and registers the result
//  the result beat shows in the cycle after that, while the next item may
//  already be accepted; no new item is taken while busy is high
//  synchronous active-low reset empties the queue, releases all keys by
//  clearing the key row valid flags, releases the button, zeroes the last
//  position and the lost flag; ram contents are left as they are since
//  only written entries and rows are ever used
//  the receiver cannot stall, so results never back up
// ----------------------------------------------------------------------------
module input_event_queue_coalescing #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ievq_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output ievq_pkg::t_result o_result
);

    // slot index width and counter width (counters run modulo 2*depth)
    localparam int unsigned SW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = SW + 1;
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] LAST_CNT = CW'(2 * QUEUE_DEPTH - 1);
    localparam logic [CW:0]   SPAN     = (CW + 1)'(2 * QUEUE_DEPTH);

    // sequencer codes
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              r_state;
    logic              n_state;
    ievq_pkg::t_item   r_item;
    logic [CW-1:0]     r_wr_cnt;
    logic [CW-1:0]     n_wr_cnt;
    logic [CW-1:0]     r_rd_cnt;
    logic [CW-1:0]     n_rd_cnt;
    logic [ievq_pkg::KEY_ROWS-1:0]  r_key_valid;
    logic [ievq_pkg::KEY_ROWS-1:0]  n_key_valid;
    logic              r_button;
    logic              n_button;
    logic [15:0]       r_last_h;
    logic [15:0]       n_last_h;
    logic [15:0]       r_last_v;
    logic [15:0]       n_last_v;
    logic              r_lost;
    logic              n_lost;
    logic              r_strobe;
    ievq_pkg::t_result r_result;
    ievq_pkg::t_result n_result;

    logic              w_accept;
    logic [CW-1:0]     w_prev_cnt;
    logic [SW-1:0]     w_raddr;
    logic              w_we;
    logic [SW-1:0]     w_waddr;
    ievq_pkg::t_entry  w_wdata;
    logic [ievq_pkg::ENTRY_W-1:0] w_rdata_raw;
    ievq_pkg::t_entry  w_rdata;
    logic [ievq_pkg::KEY_ROW_W-1:0] w_key_rdata;
    logic [ievq_pkg::KEY_ROW_W-1:0] w_key_row;
    logic [ievq_pkg::KEY_ROW_W-1:0] w_key_wdata;
    logic              w_key_we;
    logic              w_key_cur;
    logic [CW-1:0]     w_occ;
    logic [CW-1:0]     w_occ_next;
    logic [CW+4:0]     w_occ_ext;
    logic              w_full;

    // counter to slot, counters never reach twice the depth
    function automatic logic [SW-1:0] slot_of(input logic [CW-1:0] c);
        logic [CW-1:0] s;
        s = (c >= DEPTH_C) ? (c - DEPTH_C) : c;
        return s[SW-1:0];
    endfunction

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (c == LAST_CNT) ? '0 : (c + CW'(1));
    endfunction

    function automatic logic [CW-1:0] occupancy(input logic [CW-1:0] w,
                                                input logic [CW-1:0] r);
        logic [CW:0] d;
        d = (w >= r) ? ({1'b0, w} - {1'b0, r}) : ({1'b0, w} + SPAN - {1'b0, r});
        return d[CW-1:0];
    endfunction

    assign w_accept   = start && !busy;
    assign busy       = (r_state == ST_EXEC);
    assign w_prev_cnt = (r_wr_cnt == '0) ? LAST_CNT : (r_wr_cnt - CW'(1));
    assign w_occ      = occupancy(r_wr_cnt, r_rd_cnt);
    assign w_full     = (w_occ >= DEPTH_C);

    // pop reads the head, anything else looks at the newest entry
    assign w_raddr = (i_item.opcode == ievq_pkg::OP_POP) ? slot_of(r_rd_cnt)
                                                         : slot_of(w_prev_cnt);

    ievq_ram #(
        .WIDTH (ievq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = ievq_pkg::t_entry'(w_rdata_raw);

    // key down map, one row of eight keys read per item
    ievq_ram #(
        .WIDTH (ievq_pkg::KEY_ROW_W),
        .DEPTH (ievq_pkg::KEY_ROWS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_item.key_code[6:3]),
        .i_wdata (w_key_wdata),
        .i_re    (w_accept),
        .i_raddr (i_item.key_code[6:3]),
        .o_rdata (w_key_rdata)
    );

    // a row never written since reset holds only released keys
    assign w_key_row = r_key_valid[r_item.key_code[6:3]] ? w_key_rdata : '0;
    assign w_key_cur = w_key_row[r_item.key_code[2:0]];

    // read-modify-write of the held item
    always_comb begin
        n_state     = r_state;
        n_wr_cnt    = r_wr_cnt;
        n_rd_cnt    = r_rd_cnt;
        n_key_valid = r_key_valid;
        n_button    = r_button;
        n_last_h    = r_last_h;
        n_last_v    = r_last_v;
        n_lost      = r_lost;
        n_result    = '0;
        w_we        = 1'b0;
        w_waddr     = slot_of(r_wr_cnt);
        w_wdata     = '0;
        w_key_we    = 1'b0;
        w_key_wdata = w_key_row;

        if (r_state == ST_IDLE) begin
            if (w_accept) begin
                n_state = ST_EXEC;
            end
        end else begin
            n_state = ST_IDLE;
            case (r_item.opcode)
                ievq_pkg::OP_KEY: begin
                    if (w_key_cur != r_item.pressed) begin
                        n_result.activity = 1'b1;
                        if (w_full) begin
                            n_lost = 1'b1;
                        end else begin
                            w_we            = 1'b1;
                            w_wdata.kind    = ievq_pkg::KIND_KEY;
                            w_wdata.key     = r_item.key_code;
                            w_wdata.pressed = r_item.pressed;
                            n_wr_cnt        = bump(r_wr_cnt);
                            w_key_we        = 1'b1;
                            w_key_wdata[r_item.key_code[2:0]] = r_item.pressed;
                            n_key_valid[r_item.key_code[6:3]] = 1'b1;
                        end
                    end
                end
                ievq_pkg::OP_BUTTON: begin
                    if (r_button != r_item.pressed) begin
                        n_result.activity = 1'b1;
                        if (w_full) begin
                            n_lost = 1'b1;
                        end else begin
                            w_we            = 1'b1;
                            w_wdata.kind    = ievq_pkg::KIND_BUTTON;
                            w_wdata.pressed = r_item.pressed;
                            n_wr_cnt        = bump(r_wr_cnt);
                            n_button        = r_item.pressed;
                        end
                    end
                end
                ievq_pkg::OP_POS: begin
                    if (r_item.pos_h != r_last_h || r_item.pos_v != r_last_v) begin
                        n_result.activity = 1'b1;
                        w_wdata.kind      = ievq_pkg::KIND_POS;
                        w_wdata.h         = r_item.pos_h;
                        w_wdata.v         = r_item.pos_v;
                        // newest entry is a position: rewrite it in place
                        if (w_occ != '0 && w_rdata.kind == ievq_pkg::KIND_POS) begin
                            w_we     = 1'b1;
                            w_waddr  = slot_of(w_prev_cnt);
                            n_last_h = r_item.pos_h;
                            n_last_v = r_item.pos_v;
                        end else if (w_full) begin
                            n_lost = 1'b1;
                        end else begin
                            w_we     = 1'b1;
                            n_wr_cnt = bump(r_wr_cnt);
                            n_last_h = r_item.pos_h;
                            n_last_v = r_item.pos_v;
                        end
                    end
                end
                ievq_pkg::OP_POP: begin
                    if (w_occ != '0) begin
                        n_result.event_valid   = 1'b1;
                        n_result.event_kind    = w_rdata.kind;
                        n_result.event_key     = w_rdata.key;
                        n_result.event_pressed = w_rdata.pressed;
                        n_result.event_h       = w_rdata.h;
                        n_result.event_v       = w_rdata.v;
                        n_rd_cnt               = bump(r_rd_cnt);
                    end
                end
                ievq_pkg::OP_CLR_LOST: begin
                    n_lost = 1'b0;
                end
                default: begin
                    // unused opcodes only report flag and count
                end
            endcase
            n_result.events_lost = n_lost;
        end

        // count after this item, widened so it can be clipped to the field
        w_occ_next = occupancy(n_wr_cnt, n_rd_cnt);
        w_occ_ext  = (CW + 5)'(w_occ_next);
        n_result.queue_count = (w_occ_ext > (CW + 5)'(ievq_pkg::COUNT_MAX))
                             ? 5'(ievq_pkg::COUNT_MAX) : w_occ_ext[4:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_cnt    <= '0;
            r_rd_cnt    <= '0;
            r_key_valid <= '0;
            r_button    <= 1'b0;
            r_last_h    <= '0;
            r_last_v    <= '0;
            r_lost      <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_cnt    <= n_wr_cnt;
            r_rd_cnt    <= n_rd_cnt;
            r_key_valid <= n_key_valid;
            r_button    <= n_button;
            r_last_h    <= n_last_h;
            r_last_v    <= n_last_v;
            r_lost      <= n_lost;
            r_strobe    <= (r_state == ST_EXEC);
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (r_state == ST_EXEC) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // every executed item gives exactly one result beat in the next cycle
    a_one_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> o_strobe)
        else $error("executed item gave no result beat");

    a_no_stray_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> !o_strobe)
        else $error("result beat without an executed item");

    // occupancy never passes the depth
    a_occ_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= DEPTH_C)
        else $error("queue occupancy beyond depth");

    // a result without a popped entry carries zero entry fields
    a_empty_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.event_valid) |->
        (o_result.event_kind == '0 && o_result.event_key == '0 &&
         !o_result.event_pressed && o_result.event_h == '0 &&
         o_result.event_v == '0))
        else $error("entry fields set without a popped entry");

    // the lost flag rises only with a change seen by the same item
    a_lost_rise : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lost) |-> (o_strobe && o_result.activity && o_result.events_lost))
        else $error("lost flag set without a dropped change");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the input event queue: a clocked driver sends
// item beats from a pending queue, a clocked monitor predicts every accepted
// beat against its own model of the key map, button, position, ring and lost
// flag, and checks each result beat field by field against the oldest
// prediction; a directed opening is followed by random sequences under
// several sender gap settings
// ----------------------------------------------------------------------------
module tb_top;
    import ievq_pkg::*;

    localparam int unsigned QDEPTH     = 16;
    localparam int unsigned SPAN       = 2 * QDEPTH;   // counters wrap here
    localparam int unsigned QUIET_MAX  = 2000;         // watchdog limit in cycles
    localparam int unsigned PER_PHASE  = 330;          // live items per phase
    localparam int unsigned MAX_SHOWN  = 10;

    // sender gap percentage of each phase
    localparam int unsigned GAP_PCT [3] = '{0, 70, 37};

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    input_event_queue_coalescing #(
        .QUEUE_DEPTH (QDEPTH)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow of the block, same values as after reset
    // ------------------------------------------------------------------------
    t_entry       ring [QDEPTH];
    int unsigned  wr_ctr     = 0;
    int unsigned  rd_ctr     = 0;
    logic [127:0] keys_down  = '0;
    logic         button_on  = 1'b0;
    logic [15:0]  last_h     = '0;
    logic [15:0]  last_v     = '0;
    logic         lost       = 1'b0;

    t_item        items_to_send [$];
    t_result      awaited_results [$];

    // generator's own guess of the state, only used to make changes likely
    logic [127:0] gen_keys   = '0;
    logic         gen_button = 1'b0;
    logic [15:0]  gen_h      = '0;
    logic [15:0]  gen_v      = '0;

    int unsigned  idle_pct    = 0;
    bit           no_gap_run  = 1'b0;
    bit           beat_taken  = 1'b0;
    int unsigned  quiet       = 0;
    int unsigned  n_live      = 0;
    int unsigned  n_accepted  = 0;
    int unsigned  n_results   = 0;
    int unsigned  n_popped    = 0;
    int unsigned  n_merged    = 0;
    int unsigned  n_dropped   = 0;
    int unsigned  mismatches  = 0;
    t_result      want;

    function automatic int unsigned ring_fill();
        return (wr_ctr + SPAN - rd_ctr) % SPAN;
    endfunction

    // new slot at the write side, or a drop with the lost flag when full
    function automatic int claim_slot();
        int s;
        if (ring_fill() >= QDEPTH) begin
            lost = 1'b1;
            n_dropped++;
            return -1;
        end
        s = int'(wr_ctr % QDEPTH);
        wr_ctr = (wr_ctr + 1) % SPAN;
        return s;
    endfunction

    // works out the result beat of one accepted item and updates the shadow
    task automatic predict_event_result(input t_item it);
        t_result     r;
        t_entry      e;
        int          slot;
        int unsigned prev;
        int unsigned occ;
        r    = '0;
        e    = '0;
        slot = -1;
        case (it.opcode)
            OP_KEY: begin
                if (keys_down[it.key_code] != it.pressed) begin
                    r.activity = 1'b1;
                    slot = claim_slot();
                    if (slot >= 0) begin
                        e.kind    = KIND_KEY;
                        e.key     = it.key_code;
                        e.pressed = it.pressed;
                        ring[slot] = e;
                        keys_down[it.key_code] = it.pressed;
                    end
                end
            end
            OP_BUTTON: begin
                if (button_on != it.pressed) begin
                    r.activity = 1'b1;
                    slot = claim_slot();
                    if (slot >= 0) begin
                        e.kind    = KIND_BUTTON;
                        e.pressed = it.pressed;
                        ring[slot] = e;
                        button_on = it.pressed;
                    end
                end
            end
            OP_POS: begin
                if (it.pos_h != last_h || it.pos_v != last_v) begin
                    r.activity = 1'b1;
                    // fold into the newest entry when that one is a position
                    if (ring_fill() != 0) begin
                        prev = (wr_ctr == 0) ? SPAN - 1 : wr_ctr - 1;
                        if (ring[prev % QDEPTH].kind == KIND_POS) begin
                            slot = int'(prev % QDEPTH);
                            n_merged++;
                        end
                    end
                    if (slot < 0)
                        slot = claim_slot();
                    if (slot >= 0) begin
                        e.kind = KIND_POS;
                        e.h    = it.pos_h;
                        e.v    = it.pos_v;
                        ring[slot] = e;
                        last_h = it.pos_h;
                        last_v = it.pos_v;
                    end
                end
            end
            OP_POP: begin
                if (ring_fill() != 0) begin
                    e = ring[rd_ctr % QDEPTH];
                    r.event_valid   = 1'b1;
                    r.event_kind    = e.kind;
                    r.event_key     = e.key;
                    r.event_pressed = e.pressed;
                    r.event_h       = e.h;
                    r.event_v       = e.v;
                    rd_ctr = (rd_ctr + 1) % SPAN;
                    n_popped++;
                end
            end
            OP_CLR_LOST: lost = 1'b0;
            default: ;  // spare opcodes leave everything alone
        endcase
        occ = ring_fill();
        if (occ > COUNT_MAX)
            occ = COUNT_MAX;
        r.events_lost = lost;
        r.queue_count = occ[4:0];
        awaited_results.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t: %s mismatch on result %0d: expected %0h, got %0h",
                         $time, fname, n_results, exp_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // item generation
    // ------------------------------------------------------------------------
    // every field random, opcode as given
    function automatic t_item noise_item(input logic [2:0] op);
        logic [63:0] raw;
        t_item       it;
        raw = {$urandom, $urandom};
        it  = raw[$bits(t_item)-1:0];
        it.opcode = op;
        return it;
    endfunction

    function automatic t_item dir_item(input logic [2:0] op, input logic [6:0] k,
                                       input logic p, input logic [15:0] h,
                                       input logic [15:0] v);
        t_item it;
        it.opcode   = op;
        it.key_code = k;
        it.pressed  = p;
        it.pos_h    = h;
        it.pos_v    = v;
        return it;
    endfunction

    // mostly a toggle of a key from a small pool, now and then any key
    function automatic t_item key_item();
        t_item       it;
        int unsigned k;
        it = noise_item(OP_KEY);
        k  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(11);
        it.key_code = k[6:0];
        it.pressed  = ($urandom_range(4) == 0) ? gen_keys[k] : !gen_keys[k];
        gen_keys[k] = it.pressed;
        return it;
    endfunction

    function automatic t_item button_item();
        t_item it;
        it = noise_item(OP_BUTTON);
        it.pressed = ($urandom_range(4) == 0) ? gen_button : !gen_button;
        gen_button = it.pressed;
        return it;
    endfunction

    // repeats, single-axis moves and full moves
    function automatic t_item pos_item();
        t_item       it;
        int unsigned r;
        it = noise_item(OP_POS);
        r  = $urandom_range(9);
        if (r >= 3 && r != 5 && r != 6)
            gen_h = 16'($urandom_range(65535));
        if (r >= 5)
            gen_v = 16'($urandom_range(65535));
        it.pos_h = gen_h;
        it.pos_v = gen_v;
        return it;
    endfunction

    function automatic t_item any_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return key_item();
        if (r < 40)
            return button_item();
        if (r < 62)
            return pos_item();
        if (r < 88)
            return noise_item(OP_POP);
        if (r < 94)
            return noise_item(OP_CLR_LOST);
        return noise_item(OP_CLR_LOST + 3'($urandom_range(1, 3)));
    endfunction

    task automatic queue_item(input t_item it);
        items_to_send.push_back(it);
        if (it.opcode <= OP_CLR_LOST)
            n_live++;
    endtask

    task automatic add_sequence();
        int unsigned pick;
        int unsigned n;
        int unsigned r;
        pick = $urandom_range(9);
        if (pick <= 2) begin
            // run of changes with no pops, often overruns the ring
            n = $urandom_range(6, 24);
            repeat (n) begin
                r = $urandom_range(9);
                if (r < 7)
                    queue_item(key_item());
                else if (r < 8)
                    queue_item(button_item());
                else
                    queue_item(pos_item());
            end
        end else if (pick <= 4) begin
            // drain, sometimes past empty, then maybe clear the flag
            n = $urandom_range(1, 20);
            repeat (n) queue_item(noise_item(OP_POP));
            if ($urandom_range(1) == 1)
                queue_item(noise_item(OP_CLR_LOST));
        end else if (pick == 5) begin
            // mouse moving, so positions fold together
            n = $urandom_range(2, 8);
            repeat (n) queue_item(pos_item());
        end else begin
            n = $urandom_range(4, 16);
            repeat (n) queue_item(any_item());
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs change on the falling edge, a beat is held until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if ($urandom_range(39) == 0)
            no_gap_run = !no_gap_run;
        if (start && !beat_taken) begin
            // beat still waiting for the block, leave it in place
        end else if (i_rst_n && items_to_send.size() != 0 &&
                     (no_gap_run || $urandom_range(99) >= idle_pct)) begin
            start  <= 1'b1;
            i_item <= items_to_send.pop_front();
        end else begin
            start  <= 1'b0;
            i_item <= noise_item(3'($urandom_range(7)));
        end
    end

    // ------------------------------------------------------------------------
    // monitor: accept, predict and check on the rising edge, plus watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && start && !busy;
        if (beat_taken) begin
            predict_event_result(i_item);
            n_accepted++;
        end
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result beat with nothing awaited: %0h",
                             $time, o_result);
            end else begin
                want = awaited_results.pop_front();
                check_field("event_valid", 16'(want.event_valid),
                            16'(o_result.event_valid));
                check_field("event_kind", 16'(want.event_kind),
                            16'(o_result.event_kind));
                check_field("event_key", 16'(want.event_key),
                            16'(o_result.event_key));
                check_field("event_pressed", 16'(want.event_pressed),
                            16'(o_result.event_pressed));
                check_field("event_h", want.event_h, o_result.event_h);
                check_field("event_v", want.event_v, o_result.event_v);
                check_field("events_lost", 16'(want.events_lost),
                            16'(o_result.events_lost));
                check_field("activity", 16'(want.activity),
                            16'(o_result.activity));
                check_field("queue_count", 16'(want.queue_count),
                            16'(o_result.queue_count));
                n_results++;
            end
        end
        // cycles without an item taken
        if (beat_taken)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_MAX) begin
            $display("watchdog: %0d quiet cycles, %0d results still awaited",
                     quiet, awaited_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening, sender never idle
        queue_item(dir_item(OP_POP, 7'd0, 1'b0, 16'h0000, 16'h0000));     // pop when empty
        queue_item(dir_item(OP_CLR_LOST + 3'd1, 7'h7f, 1'b1, 16'hffff, 16'hffff));
        queue_item(dir_item(OP_CLR_LOST + 3'd2, 7'h55, 1'b0, 16'h5555, 16'haaaa));
        queue_item(dir_item(OP_CLR_LOST + 3'd3, 7'h2a, 1'b1, 16'haaaa, 16'h5555));
        queue_item(dir_item(OP_POS, 7'h7f, 1'b1, 16'h0000, 16'h0000));    // no move
        queue_item(dir_item(OP_KEY, 7'd0, 1'b1, 16'hffff, 16'hffff));     // lowest key
        queue_item(dir_item(OP_KEY, 7'd127, 1'b1, 16'h0000, 16'h0000));   // highest key
        queue_item(dir_item(OP_KEY, 7'd127, 1'b1, 16'h1234, 16'h5678));   // no change
        queue_item(dir_item(OP_KEY, 7'd127, 1'b0, 16'h0000, 16'h0000));   // release
        queue_item(dir_item(OP_BUTTON, 7'h7f, 1'b0, 16'hffff, 16'h0000)); // already up
        queue_item(dir_item(OP_BUTTON, 7'h7f, 1'b1, 16'h0000, 16'hffff));
        queue_item(dir_item(OP_BUTTON, 7'd0, 1'b1, 16'h0000, 16'h0000));  // no change
        queue_item(dir_item(OP_BUTTON, 7'd0, 1'b0, 16'h0000, 16'h0000));
        queue_item(dir_item(OP_POS, 7'h7f, 1'b1, 16'hffff, 16'hffff));    // new slot
        queue_item(dir_item(OP_POS, 7'h00, 1'b0, 16'h0001, 16'habcd));    // folded in
        queue_item(dir_item(OP_POS, 7'h3c, 1'b1, 16'h0000, 16'h0000));    // folded, back home
        queue_item(dir_item(OP_KEY, 7'd64, 1'b1, 16'h0000, 16'h0000));
        queue_item(dir_item(OP_POS, 7'd0, 1'b0, 16'h8000, 16'h0001));     // key is newest
        queue_item(dir_item(OP_CLR_LOST, 7'h7f, 1'b1, 16'hffff, 16'hffff));
        repeat (9) queue_item(dir_item(OP_POP, 7'h7f, 1'b1, 16'hffff, 16'hffff));
        gen_keys[64] = 1'b1;

        for (int p = 0; p < 3; p++) begin
            idle_pct = GAP_PCT[p];
            n_live   = 0;
            while (n_live < PER_PHASE)
                add_sequence();
            // let the phase drain completely before the next gap setting
            while (items_to_send.size() != 0 || start || awaited_results.size() != 0)
                @(posedge i_clk);
            repeat (4) @(posedge i_clk);
        end

        $display("covered %0d items: %0d entries popped, %0d positions folded, %0d drops",
                 n_accepted, n_popped, n_merged, n_dropped);
        $display("checked %0d results over sender gaps of 0, 70 and 37 percent, %0d mismatches",
                 n_results, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
